// ----- src/sci_pkg.sv -----
// Shared types and widths for the segment/circle intersection pipeline.
`default_nettype none
package sci_pkg;

  localparam int CoordW   = 20;
  localparam int RadiusW  = 19;
  localparam int FracW    = 17;
  localparam int LenW     = 41;
  localparam int DotW     = 42;
  localparam int DiscW    = 84;
  localparam int RootW    = DiscW / 2;
  localparam int QuotW    = FracW;
  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(10240);
  localparam logic [FracW-1:0]   FracOne     = FracW'(65536);

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [FracW-1:0] fraction;
  } out_t;

  typedef struct packed {
    logic                   ok;
    logic signed [DotW-1:0] h;
    logic [LenW-1:0]        a;
  } side_t;

endpackage
`default_nettype wire

// ----- src/sci_front.sv -----
// Front stages: differences, dot products, wide squares and discriminant.
`default_nettype none
module sci_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire sci_pkg::in_t                in_item,
  input  wire logic [sci_pkg::RadiusW-1:0] radius,
  output logic                             out_vld,
  output logic [sci_pkg::DiscW-1:0]        disc,
  output sci_pkg::side_t                   side
);

  logic [6:0] vld_r;

  logic signed [20:0] dx_r, dy_r, fx_r, fy_r;
  logic [sci_pkg::RadiusW-1:0] r_r;

  logic signed [41:0] dxdx_r, dydy_r, fxdx_r, fydy_r, fxfx_r, fyfy_r;
  logic [37:0] rr_r;

  logic [sci_pkg::LenW-1:0] a3_r;
  logic signed [sci_pkg::DotW-1:0] h3_r;
  logic signed [42:0] c3_r;

  logic [sci_pkg::LenW-1:0] a4_r;
  logic signed [sci_pkg::DotW-1:0] h4_r;
  logic [40:0] habs_r;
  logic [41:0] cabs_r;
  logic a_zero4_r, c_pos4_r;

  logic [sci_pkg::LenW-1:0] a5_r;
  logic signed [sci_pkg::DotW-1:0] h5_r;
  logic a_zero5_r, c_pos5_r;
  logic [41:0] hll_r, all_r, alh_r;
  logic [40:0] hlh_r, ahl_r, ahh_r;
  logic [39:0] hhh_r;

  logic [sci_pkg::LenW-1:0] a6_r;
  logic signed [sci_pkg::DotW-1:0] h6_r;
  logic a_zero6_r, c_pos6_r;
  logic [sci_pkg::DiscW-1:0] b6_r, ac6_r;

  logic [sci_pkg::DiscW-1:0] disc_r;
  sci_pkg::side_t side_r;

  logic signed [sci_pkg::DotW-1:0] h_neg;
  logic signed [42:0] c_neg;

  assign h_neg = -h3_r;
  assign c_neg = -c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= in_item.end_x - in_item.start_x;
      dy_r <= in_item.end_y - in_item.start_y;
      fx_r <= in_item.start_x - in_item.center_x;
      fy_r <= in_item.start_y - in_item.center_y;
      r_r  <= radius;

      dxdx_r <= dx_r * dx_r;
      dydy_r <= dy_r * dy_r;
      fxdx_r <= fx_r * dx_r;
      fydy_r <= fy_r * dy_r;
      fxfx_r <= fx_r * fx_r;
      fyfy_r <= fy_r * fy_r;
      rr_r   <= r_r * r_r;

      a3_r <= dxdx_r[40:0] + dydy_r[40:0];
      h3_r <= fxdx_r + fydy_r;
      c3_r <= $signed({1'b0, fxfx_r}) + $signed({1'b0, fyfy_r}) - $signed({5'd0, rr_r});

      a4_r      <= a3_r;
      h4_r      <= h3_r;
      habs_r    <= h3_r[41] ? h_neg[40:0] : h3_r[40:0];
      cabs_r    <= c3_r[42] ? c_neg[41:0] : c3_r[41:0];
      a_zero4_r <= (a3_r == '0);
      c_pos4_r  <= !c3_r[42] && (c3_r != '0);

      a5_r      <= a4_r;
      h5_r      <= h4_r;
      a_zero5_r <= a_zero4_r;
      c_pos5_r  <= c_pos4_r;
      hll_r     <= habs_r[20:0] * habs_r[20:0];
      hlh_r     <= habs_r[20:0] * habs_r[40:21];
      hhh_r     <= habs_r[40:21] * habs_r[40:21];
      all_r     <= a4_r[20:0] * cabs_r[20:0];
      alh_r     <= a4_r[20:0] * cabs_r[41:21];
      ahl_r     <= a4_r[40:21] * cabs_r[20:0];
      ahh_r     <= a4_r[40:21] * cabs_r[41:21];

      a6_r      <= a5_r;
      h6_r      <= h5_r;
      a_zero6_r <= a_zero5_r;
      c_pos6_r  <= c_pos5_r;
      b6_r      <= {2'b00, hhh_r, 42'd0} + {21'd0, hlh_r, 22'd0} + {42'd0, hll_r};
      ac6_r     <= {1'b0, ahh_r, 42'd0} + {21'd0, alh_r, 21'd0}
                 + {22'd0, ahl_r, 21'd0} + {42'd0, all_r};

      disc_r    <= c_pos6_r ? b6_r - ac6_r : b6_r + ac6_r;
      side_r.ok <= !a_zero6_r && !(c_pos6_r && (b6_r < ac6_r));
      side_r.h  <= h6_r;
      side_r.a  <= a6_r;
    end
  end

  assign out_vld = vld_r[6];
  assign disc    = disc_r;
  assign side    = side_r;

endmodule
`default_nettype wire

// ----- src/sci_sqrt.sv -----
// Pipelined digit-by-digit square root, one root bit per stage.
`default_nettype none
module sci_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [sci_pkg::DiscW-1:0] disc,
  input  wire sci_pkg::side_t            side_in,
  output logic                           out_vld,
  output logic [sci_pkg::RootW-1:0]      root,
  output sci_pkg::side_t                 side_out
);

  localparam int N    = sci_pkg::RootW;
  localparam int RemW = sci_pkg::RootW + 3;

  logic                        vld_r  [N];
  logic [RemW-1:0]             rem_r  [N];
  logic [N-1:0]                q_r    [N];
  logic [sci_pkg::DiscW-1:0]   rad_r  [N];
  sci_pkg::side_t              side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                      cv;
    logic [RemW-1:0]           crem;
    logic [N-1:0]              cq;
    logic [sci_pkg::DiscW-1:0] crad;
    sci_pkg::side_t            cside;
    logic [RemW-1:0]           rem_t, trial;
    logic                      ge;

    if (i == 0) begin : g_first
      assign cv    = in_vld;
      assign crem  = '0;
      assign cq    = '0;
      assign crad  = disc;
      assign cside = side_in;
    end else begin : g_next
      assign cv    = vld_r[i-1];
      assign crem  = rem_r[i-1];
      assign cq    = q_r[i-1];
      assign crad  = rad_r[i-1];
      assign cside = side_r[i-1];
    end

    assign rem_t = {crem[RemW-3:0], crad[sci_pkg::DiscW-1 -: 2]};
    assign trial = RemW'({cq, 2'b01});
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? rem_t - trial : rem_t;
        q_r[i]    <= {cq[N-2:0], ge};
        rad_r[i]  <= {crad[sci_pkg::DiscW-3:0], 2'b00};
        side_r[i] <= cside;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign root     = q_r[N-1];
  assign side_out = side_r[N-1];

endmodule
`default_nettype wire

// ----- src/sci_div.sv -----
// Root selection and pipelined restoring divider for the fraction.
`default_nettype none
module sci_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [sci_pkg::RootW-1:0] root,
  input  wire sci_pkg::side_t            side,
  output logic                           out_vld,
  output sci_pkg::out_t                  result
);

  localparam int N  = sci_pkg::QuotW;
  localparam int AW = sci_pkg::LenW;

  logic                    s1_vld_r, s2_vld_r;
  logic signed [43:0]      n1_r, n2_r;
  logic [AW-1:0]           a1_r, a2_r;
  logic                    ok1_r, hit2_r;
  logic [AW-1:0]           n_sel_r;

  logic signed [43:0] s_ext, h_ext;
  logic ok_hi, ok_lo;

  assign s_ext = $signed({2'b00, root});
  assign h_ext = 44'(side.h);
  assign ok_hi = !n1_r[43] && (n1_r[42:0] <= 43'(a1_r));
  assign ok_lo = !n2_r[43] && (n2_r[42:0] <= 43'(a1_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r    <= s_ext - h_ext;
      n2_r    <= -h_ext - s_ext;
      a1_r    <= side.a;
      ok1_r   <= side.ok;
      a2_r    <= a1_r;
      hit2_r  <= ok1_r && (ok_hi || ok_lo);
      n_sel_r <= ok_hi ? n1_r[AW-1:0] : n2_r[AW-1:0];
    end
  end

  logic          vld_r [N];
  logic [AW-1:0] rem_r [N];
  logic [AW-1:0] a_r   [N];
  logic [N-1:0]  q_r   [N];
  logic          hit_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          cv, chit;
    logic [AW-1:0] ca;
    logic [N-1:0]  cq;
    logic [AW:0]   rem_t;
    logic          ge;

    if (k == 0) begin : g_first
      assign cv    = s2_vld_r;
      assign chit  = hit2_r;
      assign ca    = a2_r;
      assign cq    = '0;
      assign rem_t = {1'b0, n_sel_r};
    end else begin : g_next
      assign cv    = vld_r[k-1];
      assign chit  = hit_r[k-1];
      assign ca    = a_r[k-1];
      assign cq    = q_r[k-1];
      assign rem_t = {rem_r[k-1], 1'b0};
    end

    assign ge = (rem_t >= {1'b0, ca});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= AW'(ge ? rem_t - {1'b0, ca} : rem_t);
        a_r[k]   <= ca;
        q_r[k]   <= {cq[N-2:0], ge};
        hit_r[k] <= chit;
      end
    end
  end

  assign out_vld         = vld_r[N-1];
  assign result.hit      = hit_r[N-1];
  assign result.fraction = hit_r[N-1] ? q_r[N-1] : '0;

endmodule
`default_nettype wire

// ----- src/segment_circle_intersection.sv -----
// Segment/circle intersection top level.
//
// Input channel in_valid/in_ready/in_data carries one segment (start, end)
// and a circle center, all signed Q12.8. The result channel
// out_valid/out_ready/out_data returns hit and an unsigned Q1.16 fraction along the
// segment, one result per item, in order. The radius is written through
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// The path from input transfer to output valid has 7 front stages
// (differences, products, split wide squares, discriminant), 42 square-root
// stages (one root bit each), 2 root-select stages, 17 divider stages (one
// quotient bit each) and the output register. One item is taken per cycle
// unless a result waits on a stalled receiver; then the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the radius to 10240
// (40.0 units).
`default_nettype none
module segment_circle_intersection (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire sci_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output sci_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sci_pkg::RadiusW-1:0] cfg_data
);

  logic en;
  logic [sci_pkg::RadiusW-1:0] radius_r;
  logic out_valid_r;
  sci_pkg::out_t out_data_r;

  logic f_vld, q_vld, d_vld;
  logic [sci_pkg::DiscW-1:0] disc;
  sci_pkg::side_t f_side, q_side;
  logic [sci_pkg::RootW-1:0] root;
  sci_pkg::out_t d_res;

  assign en        = out_ready || !out_valid_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= sci_pkg::RadiusReset;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  sci_front u_front (
    .clk, .rst_n, .en,
    .in_vld(in_valid && in_ready), .in_item(in_data), .radius(radius_r),
    .out_vld(f_vld), .disc, .side(f_side)
  );

  sci_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_vld(f_vld), .disc, .side_in(f_side),
    .out_vld(q_vld), .root, .side_out(q_side)
  );

  sci_div u_div (
    .clk, .rst_n, .en,
    .in_vld(q_vld), .root, .side(q_side),
    .out_vld(d_vld), .result(d_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= d_res;
    end
  end

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.fraction == '0)
    else $error("fraction nonzero without hit");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fraction <= sci_pkg::FracOne)
    else $error("fraction above one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
